// ===== hdl/cfm_pkg.sv =====
// ---------------------------------------------------------------------------
// cfm_pkg: shared types and constants for the frequency coefficient mask
// Widths of the datapath, register and mode codes, and the structs that
// carry one coefficient from stage to stage.
// ---------------------------------------------------------------------------
package cfm_pkg;

  localparam int unsigned COORD_W = 10;  // row / column index
  localparam int unsigned SIZE_W  = 11;  // frame size
  localparam int unsigned LIM_W   = 10;  // rect limits
  localparam int unsigned DIST_W  = 11;  // folded distance, up to 1023
  localparam int unsigned SQ_W    = 22;  // one squared distance
  localparam int unsigned D2_W    = 23;  // sum of two squares
  localparam int unsigned RAD_W   = 21;  // squared radius registers
  localparam int unsigned DATA_W  = 32;  // coefficient word
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned RIDX_W  = 3;   // register index

  // Mask shapes
  localparam logic [MODE_W-1:0] MODE_RECT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LOW    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HIGH   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BAND   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REJECT = 3'd4;

  // Register map indexes (byte address = 4 * index)
  localparam logic [RIDX_W-1:0] REG_DOMAIN   = 3'd0;
  localparam logic [RIDX_W-1:0] REG_MODE     = 3'd1;
  localparam logic [RIDX_W-1:0] REG_WIDTH    = 3'd2;
  localparam logic [RIDX_W-1:0] REG_HEIGHT   = 3'd3;
  localparam logic [RIDX_W-1:0] REG_ROW_LIM  = 3'd4;
  localparam logic [RIDX_W-1:0] REG_COL_LIM  = 3'd5;
  localparam logic [RIDX_W-1:0] REG_LOW_RAD  = 3'd6;
  localparam logic [RIDX_W-1:0] REG_HIGH_RAD = 3'd7;

  typedef struct packed {
    logic              domain_select;
    logic [MODE_W-1:0] mask_mode;
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
    logic [LIM_W-1:0]  rect_row_limit;
    logic [LIM_W-1:0]  rect_col_limit;
    logic [RAD_W-1:0]  low_radius_sq;
    logic [RAD_W-1:0]  high_radius_sq;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    logic [DIST_W-1:0]        dr;
    logic [DIST_W-1:0]        dc;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } fold_t;

  typedef struct packed {
    logic                     valid;
    logic                     rect_keep;
    logic [SQ_W-1:0]          dr_sq;
    logic [SQ_W-1:0]          dc_sq;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } dist_t;

endpackage

// ===== hdl/cfm_fold.sv =====
// ---------------------------------------------------------------------------
// cfm_fold: first pipeline stage
// Folds row and column toward the nearest corner in DFT mode, or passes
// them as distances from the top-left corner in DCT mode.
// ---------------------------------------------------------------------------
module cfm_fold
  import cfm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  logic                     in_valid,
  input  logic [COORD_W-1:0]       row,
  input  logic [COORD_W-1:0]       col,
  input  logic signed [DATA_W-1:0] re,
  input  logic signed [DATA_W-1:0] im,
  output fold_t                    stage
);

  function automatic logic [DIST_W-1:0] fold_axis(logic [COORD_W-1:0] idx,
                                                 logic [SIZE_W-1:0]  size);
    logic [SIZE_W-1:0] idx_w;
    logic [SIZE_W-1:0] half;
    idx_w = SIZE_W'(idx);
    half  = size >> 1;
    if (idx_w > half) begin
      if (size >= idx_w) begin
        fold_axis = DIST_W'(size - idx_w);
      end else begin
        fold_axis = DIST_W'(idx_w - size);
      end
    end else begin
      fold_axis = DIST_W'(idx_w);
    end
  endfunction

  logic [DIST_W-1:0] dr_next;
  logic [DIST_W-1:0] dc_next;

  always_comb begin
    if (cfg.domain_select) begin
      dr_next = DIST_W'(row);
      dc_next = DIST_W'(col);
    end else begin
      dr_next = fold_axis(row, cfg.frame_height);
      dc_next = fold_axis(col, cfg.frame_width);
    end
  end

  // Only the valid bit is reset; the payload just follows the input
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= in_valid;
    end
    stage.dr <= dr_next;
    stage.dc <= dc_next;
    stage.re <= re;
    stage.im <= im;
  end

endmodule

// ===== hdl/cfm_dist.sv =====
// ---------------------------------------------------------------------------
// cfm_dist: second pipeline stage
// Squares both folded distances and settles the rectangular decision.
// ---------------------------------------------------------------------------
module cfm_dist
  import cfm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  fold_t fold_in,
  output dist_t stage
);

  logic [DIST_W-1:0] row_lim;
  logic [DIST_W-1:0] col_lim;

  // DCT keeps twice the limit along each axis
  always_comb begin
    if (cfg.domain_select) begin
      row_lim = {cfg.rect_row_limit, 1'b0};
      col_lim = {cfg.rect_col_limit, 1'b0};
    end else begin
      row_lim = DIST_W'(cfg.rect_row_limit);
      col_lim = DIST_W'(cfg.rect_col_limit);
    end
  end

  // Only the valid bit is reset; the payload just follows the input
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else begin
      stage.valid <= fold_in.valid;
    end
    stage.rect_keep <= (fold_in.dr <= row_lim) && (fold_in.dc <= col_lim);
    stage.dr_sq     <= SQ_W'(fold_in.dr) * SQ_W'(fold_in.dr);
    stage.dc_sq     <= SQ_W'(fold_in.dc) * SQ_W'(fold_in.dc);
    stage.re        <= fold_in.re;
    stage.im        <= fold_in.im;
  end

endmodule

// ===== hdl/cfm_decide.sv =====
// ---------------------------------------------------------------------------
// cfm_decide: third pipeline stage
// Adds the squares, compares against the radii, picks the mask shape and
// registers the result.
// ---------------------------------------------------------------------------
module cfm_decide
  import cfm_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  cfg_t                     cfg,
  input  dist_t                    dist_in,
  output logic                     done,
  output logic signed [DATA_W-1:0] masked_real,
  output logic signed [DATA_W-1:0] masked_imag,
  output logic                     kept_flag
);

  logic [D2_W-1:0] d2;
  logic            below_high;
  logic            above_low;
  logic            in_band;
  logic            kept;

  always_comb begin
    d2         = D2_W'(dist_in.dr_sq) + D2_W'(dist_in.dc_sq);
    below_high = (d2 <= D2_W'(cfg.high_radius_sq));
    above_low  = (d2 >= D2_W'(cfg.low_radius_sq));
    in_band    = below_high && above_low;
    case (cfg.mask_mode)
      MODE_RECT:   kept = dist_in.rect_keep;
      MODE_LOW:    kept = below_high;
      MODE_HIGH:   kept = !below_high;
      MODE_BAND:   kept = in_band;
      MODE_REJECT: kept = !in_band;
      default:     kept = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dist_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    kept_flag   <= kept;
    masked_real <= kept ? dist_in.re : '0;
    masked_imag <= (kept && !cfg.domain_select) ? dist_in.im : '0;
  end

endmodule

// ===== hdl/frequency_coefficient_mask.sv =====
// ---------------------------------------------------------------------------
// frequency_coefficient_mask: ideal frequency-domain filter mask
// Passes or zeroes one transform coefficient per cycle by its
// distance from the spectral origin, under one of five mask shapes; other mode codes pass all.
// ---------------------------------------------------------------------------
//
//  channel   handshake              payload
//  --------  ---------------------  ---------------------------------------
//  input     start (busy is 0)      coef_row, coef_col, coef_real, coef_imag
//  result    done, one-cycle pulse  masked_real, masked_imag, kept_flag
//  config    APB write/read         psel penable pwrite paddr pwdata prdata
//
//  An accepted transaction passes three register stages (fold, square,
//  decide) before its result shows with done.
//  One transaction may enter in every cycle; busy is never raised, so the
//  throughput is one coefficient per clock.
//  The receiver cannot stall: done is a one-cycle strobe and the result is not
//  held. Synchronous reset empties the pipeline and loads the register
//  defaults; no clearing pass is needed.
//
module frequency_coefficient_mask
  import cfm_pkg::*;
#(
  parameter int unsigned MAX_DIM = 1024
) (
  input  logic                     clk,
  input  logic                     rst,
  // coefficient input
  input  logic                     start,
  output logic                     busy,
  input  logic [COORD_W-1:0]       coef_row,
  input  logic [COORD_W-1:0]       coef_col,
  input  logic signed [DATA_W-1:0] coef_real,
  input  logic signed [DATA_W-1:0] coef_imag,
  // masked result
  output logic                     done,
  output logic signed [DATA_W-1:0] masked_real,
  output logic signed [DATA_W-1:0] masked_imag,
  output logic                     kept_flag,
  // register port
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [4:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  // Reset values follow the nominal frame size, cut to the register widths
  localparam logic [SIZE_W-1:0] RST_SIZE = SIZE_W'(MAX_DIM);
  localparam logic [LIM_W-1:0]  RST_LIM  = LIM_W'(MAX_DIM / 2);

  cfg_t              cfg;
  logic              wr_en;
  logic [RIDX_W-1:0] reg_idx;
  logic              in_valid;
  fold_t             fold_stage;
  dist_t             dist_stage;

  // The pipeline never holds off the source
  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  // -------------------------------------------------------------------------
  // Register file: write on the access cycle, read back combinationally
  // -------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.domain_select  <= 1'b0;
      cfg.mask_mode      <= MODE_LOW;
      cfg.frame_width    <= RST_SIZE;
      cfg.frame_height   <= RST_SIZE;
      cfg.rect_row_limit <= RST_LIM;
      cfg.rect_col_limit <= RST_LIM;
      cfg.low_radius_sq  <= '0;
      cfg.high_radius_sq <= '1;
    end else if (wr_en) begin
      case (reg_idx)
        REG_DOMAIN:   cfg.domain_select  <= pwdata[0];
        REG_MODE:     cfg.mask_mode      <= pwdata[MODE_W-1:0];
        REG_WIDTH:    cfg.frame_width    <= pwdata[SIZE_W-1:0];
        REG_HEIGHT:   cfg.frame_height   <= pwdata[SIZE_W-1:0];
        REG_ROW_LIM:  cfg.rect_row_limit <= pwdata[LIM_W-1:0];
        REG_COL_LIM:  cfg.rect_col_limit <= pwdata[LIM_W-1:0];
        REG_LOW_RAD:  cfg.low_radius_sq  <= pwdata[RAD_W-1:0];
        REG_HIGH_RAD: cfg.high_radius_sq <= pwdata[RAD_W-1:0];
        default:      cfg.domain_select  <= cfg.domain_select;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DOMAIN:   prdata = 32'(cfg.domain_select);
      REG_MODE:     prdata = 32'(cfg.mask_mode);
      REG_WIDTH:    prdata = 32'(cfg.frame_width);
      REG_HEIGHT:   prdata = 32'(cfg.frame_height);
      REG_ROW_LIM:  prdata = 32'(cfg.rect_row_limit);
      REG_COL_LIM:  prdata = 32'(cfg.rect_col_limit);
      REG_LOW_RAD:  prdata = 32'(cfg.low_radius_sq);
      REG_HIGH_RAD: prdata = 32'(cfg.high_radius_sq);
      default:      prdata = '0;
    endcase
  end

  // -------------------------------------------------------------------------
  // Pipeline: fold -> square -> decide
  // -------------------------------------------------------------------------
  cfm_fold u_fold (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .row      (coef_row),
    .col      (coef_col),
    .re       (coef_real),
    .im       (coef_imag),
    .stage    (fold_stage)
  );

  cfm_dist u_dist (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fold_in (fold_stage),
    .stage   (dist_stage)
  );

  cfm_decide u_decide (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .dist_in     (dist_stage),
    .done        (done),
    .masked_real (masked_real),
    .masked_imag (masked_imag),
    .kept_flag   (kept_flag)
  );

  // -------------------------------------------------------------------------
  // Checks
  // -------------------------------------------------------------------------

  // Every accepted transaction comes out as a done strobe
  assert property (@(posedge clk) disable iff (rst) in_valid |-> ##3 done)
    else $error("accepted transaction did not produce a result");

  // No result without a matching earlier transaction
  assert property (@(posedge clk) disable iff (rst) done |-> $past(in_valid, 3))
    else $error("result strobe without a matching transaction");

  // A kept coefficient carries the real part it entered with
  assert property (@(posedge clk) disable iff (rst)
                   done && kept_flag |-> masked_real == $past(coef_real, 3))
    else $error("kept real part does not match the input");

  // A dropped coefficient is zero in both parts
  assert property (@(posedge clk) disable iff (rst)
                   done && !kept_flag |-> masked_real == '0 && masked_imag == '0)
    else $error("dropped coefficient is not zero");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for the frequency coefficient mask
// Drives coefficients through the start/busy port and programs the mask over
// the APB port. Results are predicted from a shadow of the registers or come
// from the directed row; each done strobe is checked field by field in order.
// ---------------------------------------------------------------------------
module tb_top;
  import cfm_pkg::*;

  localparam int unsigned QUIET_LIMIT = 1000;  // cycles with no activity
  localparam int unsigned PHASES      = 10;
  localparam int unsigned PHASE_ITEMS = 48;
  localparam int unsigned TAIL_CYCLES = 6;     // pipeline is three stages deep

  localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic [31:0]              RAD_MAX  = 32'h001F_FFFF;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     kept;
  } mask_result_t;

  // One row of the directed table: a register write or a coefficient
  typedef struct packed {
    logic                     is_write;
    logic [RIDX_W-1:0]        reg_idx;
    logic [31:0]              value;
    logic [COORD_W-1:0]       row;
    logic [COORD_W-1:0]       col;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
    logic                     typed;
    mask_result_t             want;
  } stim_row_t;

  localparam mask_result_t ZEROED = '0;

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [COORD_W-1:0]       coef_row;
  logic [COORD_W-1:0]       coef_col;
  logic signed [DATA_W-1:0] coef_real;
  logic signed [DATA_W-1:0] coef_imag;
  logic                     done;
  logic signed [DATA_W-1:0] masked_real;
  logic signed [DATA_W-1:0] masked_imag;
  logic                     kept_flag;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [4:0]               paddr;
  logic [31:0]              pwdata;
  logic [31:0]              prdata;
  logic                     pready;

  cfg_t         mask_cfg;          // shadow of the register file
  mask_result_t expected_masks[$]; // predicted results, oldest first
  stim_row_t    directed_stim[$];

  int unsigned mismatch_count = 0;
  int unsigned coefs_sent     = 0;
  int unsigned kept_seen      = 0;
  int unsigned zeroed_seen    = 0;
  int unsigned reg_writes     = 0;
  int unsigned quiet_cycles   = 0;
  logic        gaps_on;

  frequency_coefficient_mask #(.MAX_DIM(1024)) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .coef_row   (coef_row),
    .coef_col   (coef_col),
    .coef_real  (coef_real),
    .coef_imag  (coef_imag),
    .done       (done),
    .masked_real(masked_real),
    .masked_imag(masked_imag),
    .kept_flag  (kept_flag),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Distance of an index from the nearest corner along one axis. An index past
  // the frame folds to its magnitude beyond the frame edge.
  function automatic logic [DIST_W-1:0] fold_axis(input logic [COORD_W-1:0] idx,
                                                  input logic [SIZE_W-1:0] size);
    if ({1'b0, idx} > (size >> 1)) begin
      return (size >= {1'b0, idx}) ? size - {1'b0, idx} : {1'b0, idx} - size;
    end
    return {1'b0, idx};
  endfunction

  // Expected masked coefficient for one transaction under setting c
  function automatic mask_result_t predict_mask(input cfg_t c,
                                                input logic [COORD_W-1:0] row,
                                                input logic [COORD_W-1:0] col,
                                                input logic signed [DATA_W-1:0] re,
                                                input logic signed [DATA_W-1:0] im);
    logic [DIST_W-1:0] dr;
    logic [DIST_W-1:0] dc;
    logic [D2_W-1:0]   d2;
    logic              dct;
    logic              in_band;
    logic              keep;
    mask_result_t      res;
    dct = c.domain_select;
    if (dct) begin
      dr = {1'b0, row};
      dc = {1'b0, col};
    end else begin
      dr = fold_axis(row, c.frame_height);
      dc = fold_axis(col, c.frame_width);
    end
    // products are sized by d2, so no bits are lost
    d2 = D2_W'(dr) * D2_W'(dr) + D2_W'(dc) * D2_W'(dc);
    in_band = (d2 >= c.low_radius_sq) && (d2 <= c.high_radius_sq);
    case (c.mask_mode)
      MODE_RECT: begin
        if (dct) begin
          keep = ({1'b0, row} <= {c.rect_row_limit, 1'b0}) &&
                 ({1'b0, col} <= {c.rect_col_limit, 1'b0});
        end else begin
          keep = (dr <= c.rect_row_limit) && (dc <= c.rect_col_limit);
        end
      end
      MODE_LOW:    keep = (d2 <= c.high_radius_sq);
      MODE_HIGH:   keep = (d2 > c.high_radius_sq);
      MODE_BAND:   keep = in_band;
      MODE_REJECT: keep = !in_band;
      default:     keep = 1'b1;  // unused shapes pass everything
    endcase
    res.re   = keep ? re : '0;
    res.im   = (keep && !dct) ? im : '0;
    res.kept = keep;
    return res;
  endfunction

  function automatic void add_write(input logic [RIDX_W-1:0] idx, input logic [31:0] value);
    stim_row_t r;
    r          = '0;
    r.is_write = 1'b1;
    r.reg_idx  = idx;
    r.value    = value;
    directed_stim.push_back(r);
  endfunction

  function automatic void add_coef(input logic [COORD_W-1:0] row,
                                   input logic [COORD_W-1:0] col,
                                   input logic signed [DATA_W-1:0] re,
                                   input logic signed [DATA_W-1:0] im,
                                   input logic typed, input mask_result_t want);
    stim_row_t r;
    r       = '0;
    r.row   = row;
    r.col   = col;
    r.re    = re;
    r.im    = im;
    r.typed = typed;
    r.want  = want;
    directed_stim.push_back(r);
  endfunction

  // APB write: setup, access, then idle with psel low so back-to-back writes
  // never raise and drop psel in the same step. Call at a falling edge.
  task automatic write_reg(input logic [RIDX_W-1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DOMAIN:   mask_cfg.domain_select  = value[0];
      REG_MODE:     mask_cfg.mask_mode      = value[MODE_W-1:0];
      REG_WIDTH:    mask_cfg.frame_width    = value[SIZE_W-1:0];
      REG_HEIGHT:   mask_cfg.frame_height   = value[SIZE_W-1:0];
      REG_ROW_LIM:  mask_cfg.rect_row_limit = value[LIM_W-1:0];
      REG_COL_LIM:  mask_cfg.rect_col_limit = value[LIM_W-1:0];
      REG_LOW_RAD:  mask_cfg.low_radius_sq  = value[RAD_W-1:0];
      REG_HIGH_RAD: mask_cfg.high_radius_sq = value[RAD_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Offer one coefficient; start stays high on return so the next
  // transaction can follow in the very next cycle. Call at a falling edge.
  task automatic send_coef(input logic [COORD_W-1:0] row,
                           input logic [COORD_W-1:0] col,
                           input logic signed [DATA_W-1:0] re,
                           input logic signed [DATA_W-1:0] im,
                           input logic typed, input mask_result_t want);
    while (gaps_on && $urandom_range(0, 99) < 33) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start     <= 1'b1;
    coef_row  <= row;
    coef_col  <= col;
    coef_real <= re;
    coef_imag <= im;
    do @(posedge clk); while (busy);
    expected_masks.push_back(typed ? want : predict_mask(mask_cfg, row, col, re, im));
    coefs_sent++;
    @(negedge clk);
  endtask

  // Hold off the sender until every pending result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (expected_masks.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 3))
      0:       return $urandom_range(1, 64);
      1:       return 32'd1024;
      2:       return $urandom;  // anything the 11-bit field holds, zero included
      default: return $urandom_range(1, 1024);
    endcase
  endfunction

  function automatic logic [31:0] pick_limit();
    return ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 64);
  endfunction

  // Half the indices land near the origin where the radii bite
  function automatic logic [COORD_W-1:0] pick_index();
    return $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 1023))
                                : COORD_W'($urandom_range(0, 48));
  endfunction

  // Program a full register setting. The first two phases pin every field to
  // all zeros and all ones; later ones mix random values with empty bands.
  task automatic program_setting(input int unsigned phase);
    int unsigned lo_r;
    int unsigned hi_r;
    int unsigned swap_r;
    logic [31:0] hi_val;
    if (phase < 2) begin
      hi_val = (phase == 0) ? 32'h0 : 32'hFFFF_FFFF;
      write_reg(REG_DOMAIN, hi_val);
      write_reg(REG_MODE, hi_val);
      write_reg(REG_WIDTH, hi_val);
      write_reg(REG_HEIGHT, hi_val);
      write_reg(REG_ROW_LIM, hi_val);
      write_reg(REG_COL_LIM, hi_val);
      write_reg(REG_LOW_RAD, hi_val);
      write_reg(REG_HIGH_RAD, hi_val);
    end else begin
      lo_r = $urandom_range(0, 60);
      hi_r = lo_r + $urandom_range(0, 60);
      if ($urandom_range(0, 5) == 0) begin
        swap_r = lo_r;  // swap to get an empty band
        lo_r   = hi_r + 1;
        hi_r   = swap_r;
      end
      hi_val = ($urandom_range(0, 7) == 0) ? $urandom : hi_r * hi_r;
      write_reg(REG_DOMAIN, $urandom);
      write_reg(REG_MODE, ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4)
                                                    : $urandom_range(5, 7));
      write_reg(REG_WIDTH, pick_size());
      write_reg(REG_HEIGHT, pick_size());
      write_reg(REG_ROW_LIM, pick_limit());
      write_reg(REG_COL_LIM, pick_limit());
      write_reg(REG_LOW_RAD, lo_r * lo_r);
      write_reg(REG_HIGH_RAD, hi_val);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endtask

  // Result monitor: done is a one-cycle strobe, so check it at every edge
  always @(posedge clk) begin
    mask_result_t want;
    if (!rst && done) begin
      if (expected_masks.size() == 0) begin
        flag_mismatch("result with nothing pending", 32'h0, masked_real);
      end else begin
        want = expected_masks.pop_front();
        if (masked_real !== want.re) flag_mismatch("masked_real", want.re, masked_real);
        if (masked_imag !== want.im) flag_mismatch("masked_imag", want.im, masked_imag);
        if (kept_flag !== want.kept)
          flag_mismatch("kept_flag", 32'(want.kept), 32'(kept_flag));
        if (kept_flag) kept_seen++;
        else zeroed_seen++;
      end
    end
  end

  // Watchdog: any transaction, result or register access counts as progress
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    stim_row_t row_item;
    // Drive every input to a known value before the first edge
    rst       = 1'b1;
    start     = 1'b0;
    coef_row  = '0;
    coef_col  = '0;
    coef_real = '0;
    coef_imag = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    gaps_on   = 1'b1;

    // Register defaults after reset
    mask_cfg.domain_select  = 1'b0;
    mask_cfg.mask_mode      = MODE_LOW;
    mask_cfg.frame_width    = 11'd1024;
    mask_cfg.frame_height   = 11'd1024;
    mask_cfg.rect_row_limit = 10'd512;
    mask_cfg.rect_col_limit = 10'd512;
    mask_cfg.low_radius_sq  = '0;
    mask_cfg.high_radius_sq = RAD_MAX[RAD_W-1:0];

    // Defaults: DFT low-pass with the widest cutoff keeps everything
    add_coef(10'd0, 10'd0, WORD_MAX, WORD_MIN, 1'b1, {WORD_MAX, WORD_MIN, 1'b1});
    add_coef(10'd1023, 10'd1023, WORD_MIN, WORD_MAX, 1'b1, {WORD_MIN, WORD_MAX, 1'b1});
    add_coef(10'd512, 10'd513, -32'sd1, 32'sd1, 1'b0, ZEROED);
    // Rect truncation down to the origin alone
    add_write(REG_MODE, 32'(MODE_RECT));
    add_write(REG_ROW_LIM, 32'd0);
    add_write(REG_COL_LIM, 32'd0);
    add_coef(10'd0, 10'd0, 32'sd5, 32'sd6, 1'b0, ZEROED);
    add_coef(10'd0, 10'd1, 32'sd7, 32'sd8, 1'b1, ZEROED);
    // High-pass with zero cutoff drops only the origin
    add_write(REG_MODE, 32'(MODE_HIGH));
    add_write(REG_HIGH_RAD, 32'd0);
    add_coef(10'd0, 10'd0, 32'sd9, -32'sd9, 1'b1, ZEROED);
    add_coef(10'd1023, 10'd0, 32'sd10, -32'sd10, 1'b0, ZEROED);
    // Band of squared radius 4 to 9: both edges inclusive
    add_write(REG_LOW_RAD, 32'd4);
    add_write(REG_HIGH_RAD, 32'd9);
    add_write(REG_MODE, 32'(MODE_BAND));
    add_coef(10'd0, 10'd2, 32'sd11, 32'sd12, 1'b0, ZEROED);
    add_coef(10'd3, 10'd0, 32'sd13, 32'sd14, 1'b0, ZEROED);
    add_coef(10'd1, 10'd1, 32'sd15, 32'sd16, 1'b0, ZEROED);
    add_coef(10'd2, 10'd3, 32'sd17, 32'sd18, 1'b0, ZEROED);
    add_write(REG_MODE, 32'(MODE_REJECT));
    add_coef(10'd0, 10'd2, 32'sd19, 32'sd20, 1'b0, ZEROED);
    add_coef(10'd1, 10'd1, 32'sd21, 32'sd22, 1'b0, ZEROED);
    // Empty band: reject keeps all, band keeps none
    add_write(REG_LOW_RAD, 32'd10);
    add_write(REG_HIGH_RAD, 32'd5);
    add_coef(10'd0, 10'd3, 32'sd23, 32'sd24, 1'b0, ZEROED);
    add_write(REG_MODE, 32'(MODE_BAND));
    add_coef(10'd0, 10'd3, 32'sd25, 32'sd26, 1'b0, ZEROED);
    // Unused shapes pass every coefficient
    add_write(REG_MODE, 32'd5);
    add_coef(10'd700, 10'd300, 32'sd27, 32'sd28, 1'b1, {32'sd27, 32'sd28, 1'b1});
    add_write(REG_MODE, 32'd7);
    add_coef(10'd3, 10'd3, 32'sd29, 32'sd30, 1'b1, {32'sd29, 32'sd30, 1'b1});
    // DCT: top-left origin, imaginary part always dropped
    add_write(REG_DOMAIN, 32'd1);
    add_write(REG_MODE, 32'(MODE_LOW));
    add_write(REG_HIGH_RAD, RAD_MAX);
    add_coef(10'd1023, 10'd1023, WORD_MAX, WORD_MAX, 1'b1, {WORD_MAX, 32'sd0, 1'b1});
    add_write(REG_MODE, 32'(MODE_RECT));
    add_write(REG_ROW_LIM, 32'd3);
    add_write(REG_COL_LIM, 32'd3);
    add_coef(10'd6, 10'd6, 32'sd31, 32'sd32, 1'b0, ZEROED);
    add_coef(10'd7, 10'd0, 32'sd33, 32'sd34, 1'b0, ZEROED);
    // Zero frame size: every index folds to its own magnitude
    add_write(REG_DOMAIN, 32'd0);
    add_write(REG_WIDTH, 32'd0);
    add_write(REG_HEIGHT, 32'd0);
    add_write(REG_MODE, 32'(MODE_LOW));
    add_write(REG_HIGH_RAD, 32'd2);
    add_coef(10'd1, 10'd1, 32'sd35, 32'sd36, 1'b0, ZEROED);
    add_coef(10'd1, 10'd2, 32'sd37, 32'sd38, 1'b0, ZEROED);
    // Indices beyond a 100 by 100 frame
    add_write(REG_WIDTH, 32'd100);
    add_write(REG_HEIGHT, 32'd100);
    add_write(REG_MODE, 32'(MODE_HIGH));
    add_write(REG_HIGH_RAD, 32'd0);
    add_coef(10'd1000, 10'd5, 32'sd39, 32'sd40, 1'b0, ZEROED);
    add_coef(10'd100, 10'd100, 32'sd41, 32'sd42, 1'b0, ZEROED);

    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed table; drain before each write so the block is idle
    foreach (directed_stim[i]) begin
      row_item = directed_stim[i];
      if (row_item.is_write) begin
        drain_results();
        write_reg(row_item.reg_idx, row_item.value);
      end else begin
        send_coef(row_item.row, row_item.col, row_item.re, row_item.im,
                  row_item.typed, row_item.want);
      end
    end

    // Random phases: new setting, then a burst of coefficients
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      drain_results();
      program_setting(phase);
      gaps_on = (phase != 4);  // one phase streams back to back
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 6 && n == PHASE_ITEMS / 2) drain_results();
        send_coef(pick_index(), pick_index(), $urandom, $urandom, 1'b0, ZEROED);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("checked %0d coefficients (%0d kept, %0d zeroed) over %0d register writes",
             coefs_sent, kept_seen, zeroed_seen, reg_writes);
    $display("covered all mask shapes, both domains, empty bands and zero-size frames");
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
